// ===== hw/rtl/txc_pkg.sv =====
// Shared types and constants for the text console cell writer.
// Depends on nothing; every other source file uses it.
package txc_pkg;

   localparam int CHAR_W       = 8;
   localparam int COORD_W      = 8;
   localparam int LEN_W        = 10;
   localparam int INDEX_W      = 10;
   localparam int TILE_W       = 16;
   localparam int COLOR_W      = 4;
   localparam int ALIGN_W      = 2;
   localparam int TAB_W        = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 5;
   localparam int OP_W         = 3;

   localparam int CHAR_OFS     = 32;
   localparam int COLOR_SHIFT  = 12;
   localparam int VISIBLE_ROWS = 24;
   localparam int CENTRE_COL   = 16;
   localparam int RIGHT_START  = 30;

   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [TAB_W-1:0]  TAB_RESET    = 5'd2;
   localparam logic [TILE_W-1:0] FILL_RESET   = 16'hFFE0;

   typedef enum logic [OP_W-1:0] {
      OP_CHAR   = 3'd0,
      OP_GOTO   = 3'd1,
      OP_STRING = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [ALIGN_W-1:0] {
      ALIGN_FLUSH_LEFT  = 2'd0,
      ALIGN_CENTRE      = 2'd1,
      ALIGN_FLUSH_RIGHT = 2'd2
   } align_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_COLOR = 2'd0,
      CSR_ALIGNMENT  = 2'd1,
      CSR_TAB_SIZE   = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic read_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic req_is_clear;
      logic req_is_read;
      logic clear_last;
   } sts_type;

endpackage

// ===== hw/rtl/txc_if.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on txc_pkg for field widths.
interface txc_req_if;
   logic                          valid;
   logic                          ready;
   logic [txc_pkg::OP_W-1:0]      op;
   logic [txc_pkg::CHAR_W-1:0]    char_code;
   logic [txc_pkg::COORD_W-1:0]   col_target;
   logic [txc_pkg::COORD_W-1:0]   row_target;
   logic [txc_pkg::LEN_W-1:0]     string_length;
   logic [txc_pkg::INDEX_W-1:0]   read_index;

   modport source (output valid, op, char_code, col_target, row_target, string_length,
                   read_index, input ready);
   modport sink (input valid, op, char_code, col_target, row_target, string_length,
                 read_index, output ready);
endinterface

interface txc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [txc_pkg::INDEX_W-1:0]   cell_index;
   logic [txc_pkg::TILE_W-1:0]    cell_value;

   modport source (output valid, kind, cell_index, cell_value, input ready);
   modport sink (input valid, kind, cell_index, cell_value, output ready);
endinterface

interface txc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [txc_pkg::CSR_INDEX_W-1:0] index;
   logic [txc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/txc_ctrl.sv =====
// Controller state machine: clear sweep, idle, and the read wait state.
// Depends on txc_pkg for state, command and status types.
module txc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  txc_pkg::sts_type sts,
   output txc_pkg::cmd_type cmd
);
   import txc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.clear_step = 1'b0;
      cmd.read_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.req_is_clear) begin
               state_in = ST_CLEAR;
            end else if (cmd.accept && sts.req_is_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_load = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/txc_dpath.sv =====
// Datapath: cursor, settings registers, tile memory, clear counter and response register.
// Depends on txc_pkg and the txc_rsp_if / txc_csr_if interfaces.
module txc_dpath #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [txc_pkg::OP_W-1:0]      req_op,
   input  logic [txc_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [txc_pkg::COORD_W-1:0]   req_col_target,
   input  logic [txc_pkg::COORD_W-1:0]   req_row_target,
   input  logic [txc_pkg::LEN_W-1:0]     req_string_length,
   input  logic [txc_pkg::INDEX_W-1:0]   req_read_index,
   input  txc_pkg::cmd_type              cmd,
   output txc_pkg::sts_type              sts,
   txc_rsp_if.source                     rsp_ch,
   txc_csr_if.sink                       csr_ch
);
   import txc_pkg::*;

   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);
   localparam int SUM_W   = $clog2(COLUMNS + 31);
   localparam int CMP_W   = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;
   localparam int ROW_LIM = (ROWS < VISIBLE_ROWS) ? ROWS : VISIBLE_ROWS;

   localparam logic [COORD_W-1:0] COL_LIMIT = COORD_W'(COLUMNS);
   localparam logic [COORD_W-1:0] ROW_LIMIT = COORD_W'(ROW_LIM);
   localparam logic [COORD_W-1:0] COL_MAX8  = COORD_W'(COLUMNS - 1);
   localparam logic [COL_W-1:0]   COL_MAX   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]   ROW_MAX   = ROW_W'(ROWS - 1);
   localparam logic [SUM_W-1:0]   COL_WRAP  = SUM_W'(COLUMNS);
   localparam logic [ADDR_W-1:0]  LAST_CELL = ADDR_W'(CELLS - 1);

   logic [TILE_W-1:0]   tile_mem [CELLS];

   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COLOR_W-1:0]  color_ff;
   logic [ALIGN_W-1:0]  align_ff;
   logic [TAB_W-1:0]    tab_ff;
   logic [TILE_W-1:0]   fill_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic [TILE_W-1:0]   rd_data_ff;
   logic                rd_oor_ff;
   logic [INDEX_W-1:0]  rd_idx_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [TILE_W-1:0]   rsp_value_ff;

   logic                is_newline, is_tab, is_print;
   logic                char_write, rd_en, mem_we;
   logic [ADDR_W-1:0]   char_addr, waddr, raddr;
   logic [TILE_W-1:0]   char_value, wdata, fill_value;
   logic [ROW_W-1:0]    row_next;
   logic [SUM_W-1:0]    col_tab, col_inc;
   logic [LEN_W-1:0]    half_len;
   logic [4:0]          align_col;
   logic                rd_oor;

   assign is_newline = (req_char_code == CHAR_NEWLINE);
   assign is_tab     = (req_char_code == CHAR_TAB);
   assign is_print   = !is_newline && !is_tab;
   assign char_write = cmd.accept && (req_op == OP_CHAR) && is_print;
   assign rd_en      = cmd.accept && (req_op == OP_READ);

   assign char_addr  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign char_value = (TILE_W'(req_char_code) - TILE_W'(CHAR_OFS))
                       | (TILE_W'(color_ff) << COLOR_SHIFT);
   assign fill_value = TILE_W'(req_char_code) - TILE_W'(CHAR_OFS);
   assign raddr      = ADDR_W'(req_read_index);
   assign rd_oor     = CMP_W'(req_read_index) >= CMP_W'(CELLS);

   assign mem_we = char_write || cmd.clear_step;
   assign waddr  = cmd.clear_step ? clr_cnt_ff : char_addr;
   assign wdata  = cmd.clear_step ? fill_ff : char_value;

   assign row_next = (row_ff == ROW_MAX) ? row_ff : row_ff + ROW_W'(1);
   assign col_tab  = SUM_W'(col_ff) + SUM_W'(tab_ff);
   assign col_inc  = SUM_W'(col_ff) + SUM_W'(1);
   assign half_len = LEN_W'((LEN_W'(1) + LEN_W'(req_string_length >> 1))
                            - LEN_W'(!req_string_length[0]));

   always_comb begin
      align_col = 5'd0;
      unique case (align_type'(align_ff))
         ALIGN_CENTRE: begin
            if (half_len < LEN_W'(CENTRE_COL)) begin
               align_col = 5'(LEN_W'(CENTRE_COL) - half_len);
            end
         end
         ALIGN_FLUSH_RIGHT: begin
            if (req_string_length < LEN_W'(RIGHT_START)) begin
               align_col = 5'(LEN_W'(RIGHT_START) - req_string_length);
            end
         end
         default: begin
            align_col = 5'd0;
         end
      endcase
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept) begin
         case (req_op)
            OP_CHAR: begin
               if (is_newline) begin
                  col_in = '0;
                  row_in = row_next;
               end else if (is_tab && (col_tab >= COL_WRAP)) begin
                  col_in = '0;
                  row_in = row_next;
               end else if (is_tab) begin
                  col_in = COL_W'(col_tab);
               end else if (col_inc >= COL_WRAP) begin
                  col_in = '0;
                  row_in = row_next;
               end else begin
                  col_in = COL_W'(col_inc);
               end
            end
            OP_GOTO: begin
               if (req_col_target < COL_LIMIT) begin
                  col_in = COL_W'(req_col_target);
               end
               if (req_row_target < ROW_LIMIT) begin
                  row_in = ROW_W'(req_row_target);
               end
            end
            OP_STRING: begin
               if ((align_ff == ALIGN_CENTRE) || (align_ff == ALIGN_FLUSH_RIGHT)) begin
                  if (COORD_W'(align_col) > COL_MAX8) begin
                     col_in = COL_MAX;
                  end else begin
                     col_in = COL_W'(align_col);
                  end
               end
            end
            OP_CLEAR: begin
               col_in = '0;
               row_in = '0;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         color_ff   <= '0;
         align_ff   <= ALIGN_FLUSH_LEFT;
         tab_ff     <= TAB_RESET;
         fill_ff    <= FILL_RESET;
         clr_cnt_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_TEXT_COLOR: color_ff <= COLOR_W'(csr_ch.data);
               CSR_ALIGNMENT:  align_ff <= ALIGN_W'(csr_ch.data);
               CSR_TAB_SIZE:   tab_ff   <= TAB_W'(csr_ch.data);
               default: begin
                  tab_ff <= tab_ff;
               end
            endcase
         end
         if (cmd.accept && (req_op == OP_CLEAR)) begin
            fill_ff    <= fill_value;
            clr_cnt_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tile_mem[raddr];
         rd_oor_ff  <= rd_oor;
         rd_idx_ff  <= req_read_index;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (char_write || cmd.read_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_write) begin
         rsp_kind_ff  <= KIND_WRITE;
         rsp_index_ff <= INDEX_W'(char_addr);
         rsp_value_ff <= char_value;
      end else if (cmd.read_load) begin
         rsp_kind_ff  <= KIND_READ;
         rsp_index_ff <= rd_idx_ff;
         rsp_value_ff <= rd_oor_ff ? '0 : rd_data_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.cell_index = rsp_index_ff;
   assign rsp_ch.cell_value = rsp_value_ff;
   assign csr_ch.ready      = 1'b1;

   assign sts.out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign sts.req_is_clear = (req_op == OP_CLEAR);
   assign sts.req_is_read  = (req_op == OP_READ);
   assign sts.clear_last   = (clr_cnt_ff == LAST_CELL);

endmodule

// ===== hw/rtl/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer: controller plus datapath.
// Depends on txc_pkg, txc_if, txc_ctrl and txc_dpath.
//
// Character, tab, newline, goto and string-start requests stream back to back
// while the response register is free; a printable character writes one tile
// and shows the written word on the response channel the next cycle. A read
// goes through the registered tile memory read, then the read wait state that
// loads the response register. A clear, and likewise reset, sweeps the tile
// memory one cell per cycle, during which no request is taken (register writes
// still are). Responses sit in an output register, so a new request is taken
// in the same cycle that a waiting response is taken.
module text_console_cell_writer_unit #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 32
) (
   input logic        clock,
   input logic        reset,
   txc_req_if.sink    req_ch,
   txc_rsp_if.source  rsp_ch,
   txc_csr_if.sink    csr_ch
);
   import txc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   assign req_ch.ready = req_ready;

   txc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   txc_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_ch.op),
      .req_char_code     (req_ch.char_code),
      .req_col_target    (req_ch.col_target),
      .req_row_target    (req_ch.row_target),
      .req_string_length (req_ch.string_length),
      .req_read_index    (req_ch.read_index),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch)
   );

endmodule

// ===== hw/rtl/txc_checker.sv =====
// Port-level checks for the text console cell writer, bound to the top level.
// Depends on txc_pkg and text_console_cell_writer_unit.
module txc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [txc_pkg::OP_W-1:0]      req_op,
   input logic [txc_pkg::CHAR_W-1:0]    req_char_code,
   input logic [txc_pkg::INDEX_W-1:0]   req_read_index,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic [txc_pkg::INDEX_W-1:0]   rsp_cell_index,
   input logic [txc_pkg::TILE_W-1:0]    rsp_cell_value
);
   import txc_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken right after reset");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_CLEAR)) |=> !req_ready)
      else $error("request taken during clear sweep");

   a_read_response: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_READ)) |-> ##2
         (rsp_valid && (rsp_kind == KIND_READ) && (rsp_cell_index == $past(req_read_index, 2))))
      else $error("read response missing or wrong");

   a_char_response: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_CHAR) && (req_char_code != CHAR_TAB)
         && (req_char_code != CHAR_NEWLINE)) |=> (rsp_valid && (rsp_kind == KIND_WRITE)))
      else $error("character write response missing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_cell_value)))
      else $error("response dropped or changed while stalled");

endmodule

bind text_console_cell_writer_unit txc_checker u_txc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_op         (req_ch.op),
   .req_char_code  (req_ch.char_code),
   .req_read_index (req_ch.read_index),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_cell_index (rsp_ch.cell_index),
   .rsp_cell_value (rsp_ch.cell_value)
);

// ===== tb/tb.sv =====
// Self-checking bench for text_console_cell_writer_unit: drives console requests and
// register writes, predicts tile writes and cell reads, and checks every response.
// Depends on txc_pkg and the txc_if channel interfaces from the RTL.
module tb;
   import txc_pkg::*;

   localparam int COLUMNS       = 32;
   localparam int ROWS          = 32;
   localparam int CELLS         = COLUMNS * ROWS;
   localparam int SETTLE_CYCLES = CELLS + 64;
   localparam int LIMIT_CYCLES  = 400000;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [CHAR_W-1:0]  char_code;
      logic [COORD_W-1:0] col_target;
      logic [COORD_W-1:0] row_target;
      logic [LEN_W-1:0]   string_length;
      logic [INDEX_W-1:0] read_index;
   } console_req_type;

   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] cell_index;
      logic [TILE_W-1:0]  cell_value;
   } tile_resp_type;

   logic clock = 1'b0;
   logic reset;

   txc_req_if req_if ();
   txc_rsp_if rsp_if ();
   txc_csr_if csr_if ();

   text_console_cell_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   console_req_type outgoing_reqs[$];
   tile_resp_type   tile_resp_q[$];

   logic [TILE_W-1:0]  tile_model [CELLS];
   int                 cur_col;
   int                 cur_row;
   logic [COLOR_W-1:0] color_m;
   logic [ALIGN_W-1:0] align_m;
   logic [TAB_W-1:0]   tab_m;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit reqs_held      = 1'b0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void console_reset();
      for (int i = 0; i < CELLS; i++) tile_model[i] = FILL_RESET;
      cur_col = 0;
      cur_row = 0;
      color_m = '0;
      align_m = ALIGN_FLUSH_LEFT;
      tab_m   = TAB_RESET;
   endfunction

   function automatic void advance_row();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) cur_row = ROWS - 1;
      else cur_row++;
   endfunction

   task automatic console_apply(input console_req_type r, output bit produced,
                                output tile_resp_type resp);
      int x;
      int n;
      int idx;
      logic [TILE_W-1:0] word;
      produced = 1'b0;
      resp = '0;
      case (r.op)
         OP_CHAR: begin
            if (r.char_code == CHAR_NEWLINE) begin
               advance_row();
            end else if (r.char_code == CHAR_TAB) begin
               x = cur_col + int'(tab_m);
               if (x >= COLUMNS) advance_row();
               else cur_col = x;
            end else begin
               idx = cur_row * COLUMNS + cur_col;
               word = (TILE_W'(r.char_code) - TILE_W'(CHAR_OFS))
                      | (TILE_W'(color_m) << COLOR_SHIFT);
               tile_model[idx] = word;
               cur_col++;
               if (cur_col >= COLUMNS) advance_row();
               produced = 1'b1;
               resp.kind = KIND_WRITE;
               resp.cell_index = INDEX_W'(idx);
               resp.cell_value = word;
            end
         end
         OP_GOTO: begin
            if (r.col_target < COLUMNS) cur_col = int'(r.col_target);
            if (r.row_target < VISIBLE_ROWS && r.row_target < ROWS)
               cur_row = int'(r.row_target);
         end
         OP_STRING: begin
            n = int'(r.string_length);
            if (align_m == ALIGN_CENTRE) begin
               x = CENTRE_COL - n / 2;
               if (n % 2 == 1) x--;
            end else if (align_m == ALIGN_FLUSH_RIGHT) begin
               x = RIGHT_START - n;
            end else begin
               x = cur_col;
            end
            if (x < 0) x = 0;
            if (x > COLUMNS - 1) x = COLUMNS - 1;
            cur_col = x;
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               tile_model[i] = TILE_W'(r.char_code) - TILE_W'(CHAR_OFS);
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            produced = 1'b1;
            resp.kind = KIND_READ;
            resp.cell_index = r.read_index;
            resp.cell_value = (r.read_index < CELLS) ? tile_model[r.read_index] : '0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      console_req_type taken;
      tile_resp_type   resp;
      bit              produced;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken = '{op: req_if.op, char_code: req_if.char_code,
                      col_target: req_if.col_target, row_target: req_if.row_target,
                      string_length: req_if.string_length, read_index: req_if.read_index};
            console_apply(taken, produced, resp);
            if (produced) tile_resp_q.push_back(resp);
         end
         if (!req_if.valid || req_if.ready) begin
            if (!reqs_held && outgoing_reqs.size() != 0
                && $urandom_range(99) >= send_idle_pct) begin
               taken = outgoing_reqs.pop_front();
               req_if.valid         <= 1'b1;
               req_if.op            <= taken.op;
               req_if.char_code     <= taken.char_code;
               req_if.col_target    <= taken.col_target;
               req_if.row_target    <= taken.row_target;
               req_if.string_length <= taken.string_length;
               req_if.read_index    <= taken.read_index;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      tile_resp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (tile_resp_q.size() == 0) begin
               $error("unexpected response: kind %0d cell_index %0d cell_value %h",
                      rsp_if.kind, rsp_if.cell_index, rsp_if.cell_value);
               mismatch_count++;
            end else begin
               want = tile_resp_q.pop_front();
               if (rsp_if.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_if.kind);
                  mismatch_count++;
               end
               if (rsp_if.cell_index !== want.cell_index) begin
                  $error("cell_index: expected %0d, got %0d", want.cell_index,
                         rsp_if.cell_index);
                  mismatch_count++;
               end
               if (rsp_if.cell_value !== want.cell_value) begin
                  $error("cell_value: expected %h, got %h", want.cell_value,
                         rsp_if.cell_value);
                  mismatch_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("text_console_cell_writer_unit: mismatch");
         $finish;
      end
   end

   function automatic console_req_type fresh_req(logic [OP_W-1:0] op);
      console_req_type r;
      r = console_req_type'({$urandom, $urandom});
      r.op = op;
      return r;
   endfunction

   task automatic queue_char(int c);
      console_req_type r;
      r = fresh_req(OP_CHAR);
      r.char_code = CHAR_W'(c);
      outgoing_reqs.push_back(r);
   endtask

   task automatic queue_goto(int cx, int cy);
      console_req_type r;
      r = fresh_req(OP_GOTO);
      r.col_target = COORD_W'(cx);
      r.row_target = COORD_W'(cy);
      outgoing_reqs.push_back(r);
   endtask

   task automatic queue_string(int len);
      console_req_type r;
      r = fresh_req(OP_STRING);
      r.string_length = LEN_W'(len);
      outgoing_reqs.push_back(r);
   endtask

   task automatic queue_read(int ri);
      console_req_type r;
      r = fresh_req(OP_READ);
      r.read_index = INDEX_W'(ri);
      outgoing_reqs.push_back(r);
   endtask

   task automatic queue_clear(int c);
      console_req_type r;
      r = fresh_req(OP_CLEAR);
      r.char_code = CHAR_W'(c);
      outgoing_reqs.push_back(r);
   endtask

   function automatic int random_glyph();
      return ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(32, 126);
   endfunction

   task automatic queue_random(int n);
      int made;
      int pick;
      int k;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            if ($urandom_range(1)) begin
               queue_goto($urandom_range(COLUMNS - 1), $urandom_range(VISIBLE_ROWS - 1));
               made++;
            end
            queue_string(($urandom_range(15) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(40));
            made++;
            k = $urandom_range(12);
            repeat (k) begin
               if ($urandom_range(15) == 0) queue_char(CHAR_TAB);
               else queue_char(random_glyph());
               made++;
            end
            if ($urandom_range(3) == 0) begin
               queue_read($urandom_range(CELLS - 1));
               made++;
            end
            queue_char(CHAR_NEWLINE);
            made++;
         end else begin
            if (pick < 65) queue_char($urandom_range(255));
            else if (pick < 70) queue_char(CHAR_TAB);
            else if (pick < 75) queue_char(CHAR_NEWLINE);
            else if (pick < 79) queue_goto($urandom_range(255), $urandom_range(255));
            else if (pick < 83) queue_goto($urandom_range(40), $urandom_range(30));
            else if (pick < 88) queue_string($urandom_range(1023));
            else if (pick < 97) queue_read($urandom_range(CELLS - 1));
            else if (pick < 98) queue_clear($urandom_range(255));
            if (pick < 98) begin
               made++;
            end else begin
               outgoing_reqs.push_back(fresh_req(OP_READ + OP_W'($urandom_range(1, 3))));
            end
         end
      end
   endtask

   task automatic queue_alignment_checks();
      int lens[5] = '{0, 1, 2, 17, 1023};
      foreach (lens[i]) begin
         queue_string(lens[i]);
         queue_char(random_glyph() | 8'h40);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (outgoing_reqs.size() != 0 || req_if.valid || tile_resp_q.size() != 0);
   endtask

   task automatic drain_and_settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_TEXT_COLOR: color_m = val[COLOR_W-1:0];
         CSR_ALIGNMENT:  align_m = val[ALIGN_W-1:0];
         CSR_TAB_SIZE:   tab_m   = val[TAB_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic run_phase(int color, int align, int tab, int idle, int stall,
                            int n, bit pause_mid);
      int half;
      csr_write(CSR_TEXT_COLOR, CSR_DATA_W'(color));
      csr_write(CSR_ALIGNMENT, CSR_DATA_W'(align));
      csr_write(CSR_TAB_SIZE, CSR_DATA_W'(tab));
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      queue_alignment_checks();
      queue_random(n);
      if (pause_mid) begin
         half = outgoing_reqs.size() / 2;
         do @(negedge clock);
         while (outgoing_reqs.size() > half);
         reqs_held = 1'b1;
         do @(negedge clock);
         while (req_if.valid || tile_resp_q.size() != 0);
         reqs_held = 1'b0;
      end
      drain_and_settle();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = '0;
      req_if.char_code = '0;
      req_if.col_target = '0;
      req_if.row_target = '0;
      req_if.string_length = '0;
      req_if.read_index = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      console_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_read(0);
      queue_char(65);
      queue_char(0);
      queue_char(255);
      queue_char(CHAR_TAB);
      queue_char(32);
      queue_char(CHAR_NEWLINE);
      queue_goto(COLUMNS - 1, VISIBLE_ROWS - 1);
      queue_char(90);
      queue_goto(40, 255);
      repeat (7) queue_char(CHAR_NEWLINE);
      queue_goto(COLUMNS - 1, 200);
      queue_char(126);
      queue_char(97);
      queue_string(1023);
      outgoing_reqs.push_back(fresh_req(OP_READ + OP_W'(1)));
      outgoing_reqs.push_back(fresh_req(OP_READ + OP_W'(3)));
      queue_clear(255);
      queue_read(CELLS - 1);
      drain_and_settle();

      run_phase(15, ALIGN_CENTRE, 31, 0, 0, 260, 1'b1);
      run_phase(26, ALIGN_FLUSH_RIGHT, 0, 67, 0, 260, 1'b0);
      run_phase(0, 3, 17, 0, 67, 260, 1'b0);
      run_phase($urandom_range(15), ALIGN_CENTRE, $urandom_range(31), 11, 11, 240, 1'b0);

      if (mismatch_count == 0) $display("text_console_cell_writer_unit: match");
      else $display("text_console_cell_writer_unit: mismatch");
      $finish;
   end

endmodule

// ===== text_console_cell_writer_unit.f =====
hw/rtl/txc_pkg.sv
hw/rtl/txc_if.sv
hw/rtl/txc_ctrl.sv
hw/rtl/txc_dpath.sv
hw/rtl/text_console_cell_writer_unit.sv
hw/rtl/txc_checker.sv
tb/tb.sv
